// ----- design/tkcd_pkg.sv -----
package tkcd_pkg;

  // Scan modes of the detector.
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_K0      = 2'd1;
  localparam logic [1:0] MODE_K1      = 2'd2;
  localparam logic [1:0] MODE_RELEASE = 2'd3;

  // Event codes reported per key.
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_LONG  = 2'd2
  } key_event_t;

  // Configuration register map.
  localparam int unsigned CFG_ADDR_W     = 3;
  localparam logic        CFG_IDX_LONG   = 1'b0;
  localparam logic [7:0]  LONG_TICKS_RST = 8'd100;
  localparam logic [7:0]  HOLD_MAX       = 8'd255;

endpackage

// ----- design/two_key_click_long_press_detector.sv -----
// Two-key click and long-press detector.
//
// The input channel (in_valid / in_stall) carries one scan tick per word: the
// levels of key 0 and key 1 and a clear request that wipes the stored events
// and the event flag before the tick is evaluated. Every accepted tick gives
// exactly one result word on the output channel (out_valid / out_stall) with
// the current key 0 event, key 1 event and the sticky event flag.
//
// The result is registered: a tick accepted at one edge shows its result from
// the next cycle on. One tick is accepted per cycle while in_stall is low; the
// state update is a single compare and increment of the 8-bit hold counter
// between the input and the result registers. While a result waits under
// out_stall, in_stall is raised and the result and all state hold still.
//
// The APB-style port holds one register, long_press_ticks, at byte address 0.
// A press counts as long once the hold count exceeds it. Writes take effect
// at the access edge; reads return it when cfg_paddr[2] is 0, and zero otherwise.
//
// Reset clears the mode, counters, events and flag, sets long_press_ticks to
// 100 and leaves the output channel empty.
module two_key_click_long_press_detector
  import tkcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Scan tick channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_key0_down,
  input  logic                  in_key1_down,
  input  logic                  in_clear_events,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_key0_event,
  output logic [1:0]            out_key1_event,
  output logic                  out_event_flag,
  // Configuration port.
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic [7:0]  long_ticks_r;
  logic [1:0]  mode_r, mode_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic        held_r, held_nxt;
  key_event_t  ev0_r, ev0_nxt;
  key_event_t  ev1_r, ev1_nxt;
  logic        flag_r, flag_nxt;
  logic        out_valid_r;
  logic        in_accept;
  logic        cfg_write;
  logic        any_down;
  logic [7:0]  hold_inc;

  // Handshakes: a new word enters unless a result is stuck downstream.
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_LONG) ? {24'd0, long_ticks_r} : 32'd0;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r <= LONG_TICKS_RST;
    end else if (cfg_write && cfg_paddr[2] == CFG_IDX_LONG) begin
      long_ticks_r <= cfg_pwdata[7:0];
    end
  end

  assign any_down = in_key0_down | in_key1_down;
  assign hold_inc = (hold_r != HOLD_MAX) ? hold_r + 8'd1 : hold_r;

  // Next-state logic for one scan tick.
  always_comb begin
    mode_nxt = mode_r;
    hold_nxt = hold_r;
    held_nxt = held_r;
    ev0_nxt  = ev0_r;
    ev1_nxt  = ev1_r;
    flag_nxt = flag_r;
    if (in_clear_events) begin
      ev0_nxt  = EV_NONE;
      ev1_nxt  = EV_NONE;
      flag_nxt = 1'b0;
    end
    unique case (mode_r)
      MODE_IDLE: begin
        if (in_key1_down) begin
          mode_nxt = MODE_K1;
        end else if (in_key0_down) begin
          mode_nxt = MODE_K0;
        end
        hold_nxt = 8'd0;
        held_nxt = 1'b0;
      end
      MODE_K0, MODE_K1: begin
        if (any_down) begin
          held_nxt = 1'b1;
          hold_nxt = hold_inc;
          if (hold_inc > long_ticks_r) begin
            // Long press: key 1 wins when both are held.
            flag_nxt = 1'b1;
            ev0_nxt  = in_key1_down ? EV_NONE : EV_LONG;
            ev1_nxt  = in_key1_down ? EV_LONG : EV_NONE;
            hold_nxt = 8'd0;
            held_nxt = 1'b0;
            mode_nxt = MODE_RELEASE;
          end
        end else if (held_r) begin
          // Click on the confirmed key.
          ev0_nxt  = (mode_r == MODE_K0) ? EV_CLICK : EV_NONE;
          ev1_nxt  = (mode_r == MODE_K0) ? EV_NONE : EV_CLICK;
          flag_nxt = 1'b1;
          mode_nxt = MODE_RELEASE;
        end else begin
          // Released without a held tick: drop the reports.
          mode_nxt = MODE_IDLE;
          ev0_nxt  = EV_NONE;
          ev1_nxt  = EV_NONE;
        end
      end
      MODE_RELEASE: begin
        if (!any_down) begin
          mode_nxt = MODE_IDLE;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase
  end

  // State and result registers; the reports are the result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      hold_r      <= 8'd0;
      held_r      <= 1'b0;
      ev0_r       <= EV_NONE;
      ev1_r       <= EV_NONE;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        mode_r <= mode_nxt;
        hold_r <= hold_nxt;
        held_r <= held_nxt;
        ev0_r  <= ev0_nxt;
        ev1_r  <= ev1_nxt;
        flag_r <= flag_nxt;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key0_event = ev0_r;
  assign out_key1_event = ev1_r;
  assign out_event_flag = flag_r;

  // A stored report always comes with the sticky flag set.
  a_report_has_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (ev0_r != EV_NONE || ev1_r != EV_NONE) |-> flag_r)
    else $error("report stored without event flag");

  // At most one key carries a report.
  a_single_report: assert property (@(posedge clk) disable iff (!rst_n)
    !(ev0_r != EV_NONE && ev1_r != EV_NONE))
    else $error("both keys report at once");

  // Every accepted tick yields a result in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted tick produced no result");

  // The hold count is zero whenever the detector sits idle after a tick.
  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && mode_r == MODE_IDLE) |=> (hold_r == 8'd0 && !held_r))
    else $error("hold count not cleared in idle");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

import tkcd_pkg::*;

// Tracks the detector state for every accepted scan tick and queues the report
// word that tick must produce, then compares returned words against it.
class key_event_scoreboard;
  typedef struct packed {
    key_event_t key0;
    key_event_t key1;
    logic       flag;
  } report_t;

  logic [1:0] scan_mode;
  logic [7:0] hold_count;
  bit         held_once;
  key_event_t key0_report;
  key_event_t key1_report;
  bit         report_flag;
  logic [7:0] long_ticks;
  report_t    expected_reports[$];
  int         errors;

  function new();
    scan_mode   = MODE_IDLE;
    hold_count  = '0;
    held_once   = 1'b0;
    key0_report = EV_NONE;
    key1_report = EV_NONE;
    report_flag = 1'b0;
    long_ticks  = LONG_TICKS_RST;
    errors      = 0;
  endfunction

  function void set_threshold(logic [7:0] value);
    long_ticks = value;
  endfunction

  // Advance the detector by one tick and queue the report word it leaves behind.
  function void note_tick(bit key0, bit key1, bit clear);
    report_t want;
    if (clear) begin
      key0_report = EV_NONE;
      key1_report = EV_NONE;
      report_flag = 1'b0;
    end
    case (scan_mode)
      MODE_IDLE: begin
        // Key 1 wins when both go down together.
        if (key0) scan_mode = MODE_K0;
        if (key1) scan_mode = MODE_K1;
        hold_count = '0;
        held_once  = 1'b0;
      end
      MODE_K0, MODE_K1: begin
        if (key0 || key1) begin
          held_once = 1'b1;
          if (hold_count != HOLD_MAX) hold_count = hold_count + 8'd1;
          if (hold_count > long_ticks) begin
            // Long press follows the keys actually held, key 1 winning.
            report_flag = 1'b1;
            if (key0) begin
              key0_report = EV_LONG;
              key1_report = EV_NONE;
            end
            if (key1) begin
              key1_report = EV_LONG;
              key0_report = EV_NONE;
            end
            hold_count = '0;
            held_once  = 1'b0;
            scan_mode  = MODE_RELEASE;
          end
        end else if (held_once) begin
          // Release after a held tick is a click on the confirmed key.
          if (scan_mode == MODE_K0) begin
            key0_report = EV_CLICK;
            key1_report = EV_NONE;
          end else begin
            key1_report = EV_CLICK;
            key0_report = EV_NONE;
          end
          report_flag = 1'b1;
          scan_mode   = MODE_RELEASE;
        end else begin
          // A bounce with no held tick wipes the reports but keeps the flag.
          scan_mode   = MODE_IDLE;
          key0_report = EV_NONE;
          key1_report = EV_NONE;
        end
      end
      default: begin
        if (!(key0 || key1)) scan_mode = MODE_IDLE;
      end
    endcase
    want.key0 = key0_report;
    want.key1 = key1_report;
    want.flag = report_flag;
    expected_reports = {expected_reports, want};
  endfunction

  // Compare one returned word with the oldest queued report.
  function void check_report(logic [1:0] key0, logic [1:0] key1, logic flag);
    report_t want;
    if (expected_reports.size() == 0) begin
      $error("report word arrived with none expected");
      errors++;
      return;
    end
    want = expected_reports.pop_front();
    if (key0 !== want.key0) begin
      $error("key0_event: expected %0d, got %0d", want.key0, key0);
      errors++;
    end
    if (key1 !== want.key1) begin
      $error("key1_event: expected %0d, got %0d", want.key1, key1);
      errors++;
    end
    if (flag !== want.flag) begin
      $error("event_flag: expected %0d, got %0d", want.flag, flag);
      errors++;
    end
  endfunction
endclass

module tb;
  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic                  in_key0_down    = 1'b0;
  logic                  in_key1_down    = 1'b0;
  logic                  in_clear_events = 1'b0;
  logic                  out_stall       = 1'b0;
  logic                  cfg_psel        = 1'b0;
  logic                  cfg_penable     = 1'b0;
  logic                  cfg_pwrite      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr       = '0;
  logic [31:0]           cfg_pwdata      = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic [1:0]            out_key0_event;
  logic [1:0]            out_key1_event;
  logic                  out_event_flag;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  key_event_scoreboard events_sb = new();
  int unsigned         send_idle_pct = 0;
  int unsigned         stall_pct = 0;
  int                  ticks_sent = 0;

  // Directed ticks, bit order {clear, key1, key0}, threshold 2.
  logic [2:0] directed_ticks[25] = '{
    3'b000,
    3'b001, 3'b001, 3'b000, 3'b000,
    3'b011, 3'b011, 3'b011, 3'b011, 3'b001, 3'b000,
    3'b010, 3'b000,
    3'b001, 3'b010, 3'b010, 3'b010, 3'b100,
    3'b010, 3'b010, 3'b100,
    3'b000, 3'b101, 3'b110, 3'b000
  };
  int phase_thr[6] = '{1, 6, 254, 12, 255, 3};
  int phase_len[6] = '{100, 100, 120, 100, 120, 100};

  two_key_click_long_press_detector u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_key0_down    (in_key0_down),
    .in_key1_down    (in_key1_down),
    .in_clear_events (in_clear_events),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_key0_event  (out_key0_event),
    .out_key1_event  (out_key1_event),
    .out_event_flag  (out_event_flag),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic bit roll(int unsigned pct);
    return $urandom_range(1, 100) <= pct;
  endfunction

  // Result side: check each accepted word, then pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      events_sb.check_report(out_key0_event, out_key1_event, out_event_flag);
    end
    out_stall <= roll(stall_pct);
  end

  // Offer one scan tick word and hold it until the block takes it.
  task automatic send_tick(input bit key0, input bit key1, input bit clear);
    while (roll(send_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_key0_down    <= key0;
    in_key1_down    <= key1;
    in_clear_events <= clear;
    do @(posedge clk); while (in_stall);
    events_sb.note_tick(key0, key1, clear);
    ticks_sent++;
  endtask

  // Stop sending and wait for every outstanding report word.
  task automatic drain();
    in_valid <= 1'b0;
    while (events_sb.expected_reports.size() != 0) @(posedge clk);
  endtask

  // Read the threshold register back and compare its low byte.
  task automatic cfg_read_check(input logic [7:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= CFG_ADDR_W'(4 * CFG_IDX_LONG);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[7:0] !== value) begin
      $error("long_press_ticks: expected %0d, got %0d", value, cfg_prdata[7:0]);
      events_sb.errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Write the threshold, then read it back in a back-to-back transfer.
  task automatic cfg_write(input logic [7:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(4 * CFG_IDX_LONG);
    cfg_pwdata  <= {24'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    events_sb.set_threshold(value);
    cfg_read_check(value);
  endtask

  // One press with random keys and hold length, or a short burst of noise.
  task automatic run_press(input int thr);
    int         hold_ticks;
    logic [1:0] keys;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 6)) begin
        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end
      return;
    end
    keys = 2'($urandom_range(1, 3));
    // Half the holds are short, half sit around the threshold.
    if ($urandom_range(0, 1)) hold_ticks = $urandom_range(0, 6);
    else hold_ticks = $urandom_range(thr > 0 ? thr - 1 : 0, thr + 3);
    send_tick(keys[0], keys[1], roll(8));
    repeat (hold_ticks) begin
      if (roll(15)) keys = 2'($urandom_range(1, 3));
      send_tick(keys[0], keys[1], roll(8));
    end
    repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'b0, roll(8));
  endtask

  // Main sequence: reset, directed ticks, then random phases.
  initial begin
    int p;
    int phase_end;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    cfg_read_check(LONG_TICKS_RST);
    cfg_write(8'd2);
    foreach (directed_ticks[i]) begin
      send_tick(directed_ticks[i][0], directed_ticks[i][1], directed_ticks[i][2]);
    end
    for (p = 0; p < 6; p++) begin
      drain();
      cfg_write(phase_thr[p][7:0]);
      send_idle_pct = (p % 4 == 1) ? 62 : (p % 4 == 3) ? 13 : 0;
      stall_pct     = (p % 4 == 2) ? 62 : (p % 4 == 3) ? 13 : 0;
      phase_end     = ticks_sent + phase_len[p];
      while (ticks_sent < phase_end) run_press(phase_thr[p]);
    end
    drain();
    repeat (4) @(posedge clk);
    if (events_sb.errors == 0 && events_sb.expected_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
